@@ design/tlas_pkg.sv @@
// Shared constants and the outcome grading function for the table-learning
// action selector. No dependencies.
package tlas_pkg;

  // Table geometry; both counts are powers of two so that indexes are bit fields
  localparam int PATTERN_COUNT = 2048;
  localparam int ACTION_COUNT  = 8;
  localparam int IDX_W         = $clog2(PATTERN_COUNT);
  localparam int ACT_W         = $clog2(ACTION_COUNT);
  localparam int OADDR_W       = IDX_W + ACT_W;
  localparam int OUT_DEPTH     = PATTERN_COUNT * ACTION_COUNT;

  // Field widths
  localparam int PAT_W    = 11;
  localparam int RND_W    = 7;
  localparam int CHOICE_W = 3;
  localparam int FILL_W   = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 1;
  localparam int GRADE_W  = 16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXPLORE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIXED   = 1'b1;

  // Register reset values
  localparam logic [CFG_W-1:0] EXPLORE_RESET = 8'd2;
  localparam logic [CFG_W-1:0] MIXED_RESET   = 8'd6;

  localparam logic [FILL_W-1:0] FILL_MAX    = 8'd255;
  localparam logic [RND_W-1:0]  EXPLORE_CUT = 7'd50;

  // Grade terms: clear obstacle bits add, each direction or distance step costs
  localparam logic [GRADE_W-1:0] GRADE_BASE  = 16'd8000;
  localparam logic [GRADE_W-1:0] SIDE_GRADE  = 16'd8000;
  localparam logic [GRADE_W-1:0] FRONT_GRADE = 16'd40000;
  localparam int                 STEP_COST   = 250;

  // Grade of a stored pattern; never negative, at most 64000
  function automatic logic [GRADE_W-1:0] grade_of(input logic [PAT_W-1:0] p);
    logic [GRADE_W-1:0] g;
    logic [4:0]         steps;
    g = GRADE_BASE;
    if (!p[0]) g = g + SIDE_GRADE;
    if (!p[1]) g = g + FRONT_GRADE;
    if (!p[2]) g = g + SIDE_GRADE;
    steps = 5'(p[6:3]) + 5'(p[10:7]);
    return g - GRADE_W'(STEP_COST * int'(steps));
  endfunction

endpackage

@@ design/table_learning_action_selector_core.sv @@
// Sequence after the start beat: fill count check, a scan through the outcome memory
// read port at one entry a cycle, report; done is registered in the report state. A
// new item is taken only when the last one is through; start is taken again in the
// done cycle. Reset: synchronous rst starts a clearing pass over the outcome and fill
// count memories; busy is high during it, config writes are still taken. The result
// strobe done lasts one cycle and the receiver cannot stall it.
module table_learning_action_selector_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [tlas_pkg::PAT_W-1:0]      current_pattern,
  input  logic [tlas_pkg::RND_W-1:0]      random_percent,
  input  logic                            cfg_we,
  input  logic [tlas_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlas_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                            done,
  output logic [tlas_pkg::CHOICE_W-1:0]   chosen_action
);
  import tlas_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [ACT_W:0] SCAN_END = (ACT_W+1)'(ACTION_COUNT);

  logic [2:0]          state;
  logic [OADDR_W-1:0]  clr_cnt;
  logic [CFG_W-1:0]    explore_threshold;
  logic [CFG_W-1:0]    mixed_threshold;
  logic [IDX_W-1:0]    last_idx;
  logic [ACT_W-1:0]    last_act;
  logic [IDX_W-1:0]    cur_idx;
  logic [RND_W-1:0]    cur_rnd;
  logic                explore_mode;
  logic [ACT_W:0]      scan_cnt;
  logic                rd_pend;
  logic [ACT_W-1:0]    rd_act;
  logic                best_valid;
  logic [GRADE_W-1:0]  best_grade;
  logic                found;
  logic [ACT_W-1:0]    sel_act;

  // Memories
  logic [PAT_W-1:0]    outcome_mem [0:OUT_DEPTH-1];
  logic [FILL_W-1:0]   fill_mem    [0:PATTERN_COUNT-1];
  logic [PAT_W-1:0]    rd_data;
  logic [FILL_W-1:0]   fill_q;

  logic                accept;
  logic                o_we;
  logic [OADDR_W-1:0]  o_waddr;
  logic [PAT_W-1:0]    o_wdata;
  logic [OADDR_W-1:0]  o_raddr;
  logic                f_we;
  logic [IDX_W-1:0]    f_waddr;
  logic [FILL_W-1:0]   f_wdata;
  logic                issue;
  logic                empty;
  logic [GRADE_W-1:0]  cand_grade;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign issue  = (state == S_SCAN) && (scan_cnt < SCAN_END);
  assign empty  = (rd_data == '0);
  assign cand_grade = grade_of(rd_data);
  assign o_raddr = {cur_idx, scan_cnt[ACT_W-1:0]};

  // Outcome write: clear sweep, or the new pattern into the previous cell
  always_comb begin
    o_we    = 1'b0;
    o_waddr = {last_idx, last_act};
    o_wdata = current_pattern;
    if (state == S_CLEAR) begin
      o_we    = 1'b1;
      o_waddr = clr_cnt;
      o_wdata = '0;
    end else if (accept) begin
      o_we = 1'b1;
    end
  end

  // Fill count write: clear sweep, or bump after a successful explore
  always_comb begin
    f_we    = 1'b0;
    f_waddr = cur_idx;
    f_wdata = fill_q + 1'b1;
    if (state == S_CLEAR) begin
      f_we    = 1'b1;
      f_waddr = clr_cnt[IDX_W-1:0];
      f_wdata = '0;
    end else if (state == S_DONE && explore_mode && found && fill_q != FILL_MAX) begin
      f_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_we) outcome_mem[o_waddr] <= o_wdata;
    rd_data <= outcome_mem[o_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) fill_mem[f_waddr] <= f_wdata;
    if (accept) fill_q <= fill_mem[current_pattern[IDX_W-1:0]];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      explore_threshold <= EXPLORE_RESET;
      mixed_threshold   <= MIXED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EXPLORE: explore_threshold <= cfg_wdata;
        REG_MIXED:   mixed_threshold   <= cfg_wdata;
        default:     ;
      endcase
    end
  end

  // Sequencer: clear, latch, pick mode, scan actions through the grade unit, report
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      last_idx <= '0;
      last_act <= '0;
      done     <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            cur_idx <= current_pattern[IDX_W-1:0];
            cur_rnd <= random_percent;
            state   <= S_FILL;
          end
        end
        S_FILL: begin
          explore_mode <= (fill_q <= explore_threshold) ||
                          ((fill_q <= mixed_threshold) && (cur_rnd < EXPLORE_CUT));
          scan_cnt   <= '0;
          rd_pend    <= 1'b0;
          best_valid <= 1'b0;
          best_grade <= '0;
          found      <= 1'b0;
          sel_act    <= '0;
          state      <= S_SCAN;
        end
        S_SCAN: begin
          rd_pend <= issue;
          rd_act  <= scan_cnt[ACT_W-1:0];
          if (issue) scan_cnt <= scan_cnt + 1'b1;
          // grade and compare the entry read last cycle
          if (rd_pend) begin
            if (explore_mode) begin
              if (!found && empty) begin
                found   <= 1'b1;
                sel_act <= rd_act;
              end
            end else if (!empty && (!best_valid || cand_grade >= best_grade)) begin
              best_valid <= 1'b1;
              best_grade <= cand_grade;
              sel_act    <= rd_act;
            end
          end
          if (!issue && !rd_pend) state <= S_DONE;
        end
        S_DONE: begin
          last_idx      <= cur_idx;
          last_act      <= sel_act;
          chosen_action <= CHOICE_W'(sel_act);
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/tlas_checker.sv @@
// Port-level checks for the table-learning action selector core.
// Depends on table_learning_action_selector_core; bound to it below.
module tlas_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Accepted beat puts the block to work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted beat");

  // Result strobe comes only at the end of a work interval
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("done without preceding work");

  // One strobe per item
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("done held for more than one cycle");

  // An item is not finished at once: no result soon after acceptance
  a_no_fast_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 !done)
    else $error("result too soon after accepted beat");

endmodule

bind table_learning_action_selector_core tlas_checker u_tlas_checker (.*);
